// File: rtl/gcdlcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the GCD / LCM unit.
// Used by gcdlcm_ctrl, gcdlcm_dp and gcd_lcm_unit; depends on nothing else.

package gcdlcm_pkg;

    localparam int VALUE_WIDTH    = 31;
    localparam int DIVISOR_WIDTH  = 31;
    localparam int MULTIPLE_WIDTH = 62;
    localparam int PRODUCT_WIDTH  = 2 * VALUE_WIDTH;
    localparam int COUNT_WIDTH    = $clog2(VALUE_WIDTH);

    localparam logic [COUNT_WIDTH-1:0] DIV_LAST = COUNT_WIDTH'(VALUE_WIDTH - 1);

    typedef struct packed {
        logic [30:0] first_value;
        logic [30:0] second_value;
    } in_t;

    typedef struct packed {
        logic [DIVISOR_WIDTH-1:0]  divisor_result;
        logic [MULTIPLE_WIDTH-1:0] multiple_result;
        logic                      zero_operand_error;
    } out_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic shift_step;
        logic div_init;
        logic div_step;
        logic mult;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic zero_op;
        logic gcd_equal;
        logic k_zero;
        logic div_last;
    } status_t;

endpackage

// File: rtl/gcd_lcm_unit.sv
`timescale 1ns / 1ps
// Top level of the GCD / LCM unit: joins the controller and the datapath.
// Depends on gcdlcm_pkg, gcdlcm_ctrl and gcdlcm_dp.

// Each request carries two operands; the unit returns their greatest common
// divisor, their least common multiple at full 62-bit width, and an error
// flag that is set (with both numbers zero) when either operand is zero.
// A request is worked on alone: a load, a binary GCD loop of halving and
// subtract-and-halve steps, one doubling step per common factor of two to
// restore it, a VALUE_WIDTH-step restoring division of the first operand
// by the divisor, a multiply and a write of the result register. A zero
// operand goes from the GCD state straight to the result write. The result
// waits in an output register, so a new request is taken as soon as the
// previous one has been written there.

module gcd_lcm_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gcdlcm_pkg::in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output gcdlcm_pkg::out_t out_data
);

    gcdlcm_pkg::cmd_t    cmd;
    gcdlcm_pkg::status_t status;

    gcdlcm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gcdlcm_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// File: rtl/gcdlcm_dp.sv
`timescale 1ns / 1ps
// Datapath of the GCD / LCM unit: binary GCD, restoring divider, multiplier
// and the result register. Depends on gcdlcm_pkg; driven by gcdlcm_ctrl.

module gcdlcm_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  gcdlcm_pkg::in_t     in_data,
    input  gcdlcm_pkg::cmd_t    cmd,
    output gcdlcm_pkg::status_t status,
    output gcdlcm_pkg::out_t    out_data
);

    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   op_a_reg, op_a_next;
    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   op_b_reg, op_b_next;
    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   x_reg, x_next;
    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   y_reg, y_next;
    logic [gcdlcm_pkg::COUNT_WIDTH-1:0]   k_reg, k_next;
    logic [gcdlcm_pkg::COUNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   rem_reg, rem_next;
    logic [gcdlcm_pkg::VALUE_WIDTH-1:0]   quo_reg, quo_next;
    logic [gcdlcm_pkg::PRODUCT_WIDTH-1:0] prod_reg, prod_next;
    gcdlcm_pkg::out_t                     out_reg, out_next;

    logic [gcdlcm_pkg::VALUE_WIDTH:0]     trial;
    logic [gcdlcm_pkg::VALUE_WIDTH:0]     trial_diff;
    logic                                 err;

    assign err = (op_a_reg == '0) || (op_b_reg == '0);

    assign status.zero_op   = err;
    assign status.gcd_equal = (x_reg == y_reg);
    assign status.k_zero    = (k_reg == '0);
    assign status.div_last  = (cnt_reg == gcdlcm_pkg::DIV_LAST);

    // One restoring-division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    assign trial      = {rem_reg, quo_reg[gcdlcm_pkg::VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, x_reg};

    always_comb
    begin
        op_a_next = op_a_reg;
        op_b_next = op_b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        prod_next = prod_reg;
        out_next  = out_reg;

        if (cmd.load)
        begin
            op_a_next = in_data.first_value[gcdlcm_pkg::VALUE_WIDTH-1:0];
            op_b_next = in_data.second_value[gcdlcm_pkg::VALUE_WIDTH-1:0];
            x_next    = in_data.first_value[gcdlcm_pkg::VALUE_WIDTH-1:0];
            y_next    = in_data.second_value[gcdlcm_pkg::VALUE_WIDTH-1:0];
            k_next    = '0;
        end

        if (cmd.gcd_step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end

        // Restore the common factors of two, one per cycle.
        if (cmd.shift_step)
        begin
            x_next = x_reg << 1;
            k_next = k_reg - 1'b1;
        end

        if (cmd.div_init)
        begin
            rem_next = '0;
            quo_next = op_a_reg;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            if (!trial_diff[gcdlcm_pkg::VALUE_WIDTH])
            begin
                rem_next = trial_diff[gcdlcm_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[gcdlcm_pkg::VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gcdlcm_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[gcdlcm_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.mult)
        begin
            prod_next = gcdlcm_pkg::PRODUCT_WIDTH'(quo_reg)
                      * gcdlcm_pkg::PRODUCT_WIDTH'(op_b_reg);
        end

        if (cmd.publish)
        begin
            if (err)
            begin
                out_next.divisor_result  = '0;
                out_next.multiple_result = '0;
            end
            else
            begin
                out_next.divisor_result  = gcdlcm_pkg::DIVISOR_WIDTH'(x_reg);
                out_next.multiple_result = gcdlcm_pkg::MULTIPLE_WIDTH'(prod_reg);
            end
            out_next.zero_operand_error = err;
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign out_data = out_reg;

    // The reduction loop only ever sees two nonzero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> (x_reg != '0) && (y_reg != '0))
        else $error("GCD step on a zero operand");

    // The divider never runs past its last quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && status.div_last |=> !cmd.div_step)
        else $error("Divider stepped beyond the operand width");

    // A shift step is only commanded while a factor of two is left to restore.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_step |-> !status.k_zero)
        else $error("Shift step with no factor of two left");

endmodule

// File: rtl/gcdlcm_ctrl.sv
`timescale 1ns / 1ps
// Control state machine of the GCD / LCM unit: sequences the datapath and
// runs both handshakes. Depends on gcdlcm_pkg.

module gcdlcm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gcdlcm_pkg::status_t status,
    output gcdlcm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_SHIFT,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                priority if (status.zero_op)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.gcd_equal)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (status.k_zero)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait until the previous result has left the output register.
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> slot_free)
        else $error("Result register overwritten before it was taken");

    // At most one datapath operation is commanded per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("Conflicting datapath commands");

    // Output valid only rises as a result is published.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.publish))
        else $error("Output valid without a published result");

    // After a request is taken, no new one is taken until it is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Second request accepted while one is in progress");

endmodule
